// ===== rtl/irpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// irpdt_pkg
// Types and constants shared by the infrared pulse-distance transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

	localparam int MAX_MARKS_DEF = 26;

	localparam int SAVE_MARKS       = 26;
	localparam int INTR_PULSES      = 14;
	localparam int BINARY_MAX_BITS  = 16;

	localparam int CFG_DATA_W  = 10;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_BURST_UNIT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTR_WAIT      = 2'd2;

	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_TRIGGER     = 3'd1;
	localparam logic [2:0] CMD_TRIGGER_INT = 3'd2;
	localparam logic [2:0] CMD_STOP        = 3'd3;
	localparam logic [2:0] CMD_BINARY      = 3'd4;
	localparam logic [2:0] CMD_SAVE        = 3'd5;
	localparam logic [2:0] CMD_TOGGLE      = 3'd6;

	localparam logic [3:0] TRIGGER_PATTERN = 4'hA;
	localparam logic [3:0] STOP_PATTERN    = 4'h6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_INTR = 2'd1,
		PH_MARK = 2'd2,
		PH_WAIT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] value;
		logic [4:0]  bit_count;
		logic        turn_on;
	} req_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic rejected;
		logic finished;
	} res_t;

	typedef struct packed {
		logic [5:0] burst_unit;
		logic [7:0] gap_ticks;
		logic [9:0] interrupt_wait_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] pulses_left;
		logic       half_select;
		logic [9:0] wait_count;
		logic       idle_high;
		logic       pin_level;
	} tx_state_t;

endpackage

// ===== rtl/irpdt_step.sv =====
// ----------------------------------------------------------------------------
// irpdt_step
// Next-state and result logic for one carrier half tick.
// ----------------------------------------------------------------------------
module irpdt_step #(
	parameter int MAX_MARKS = irpdt_pkg::MAX_MARKS_DEF
) (
	input  irpdt_pkg::req_t                    req,
	input  irpdt_pkg::cfg_t                    cfg,
	input  irpdt_pkg::tx_state_t               st,
	input  logic [MAX_MARKS-1:0]               pattern,
	input  logic [$clog2(MAX_MARKS+1)-1:0]     marks_left,
	output irpdt_pkg::tx_state_t               st_nxt,
	output logic [MAX_MARKS-1:0]               pattern_nxt,
	output logic [$clog2(MAX_MARKS+1)-1:0]     marks_left_nxt,
	output irpdt_pkg::res_t                    res
);
	import irpdt_pkg::*;

	localparam int MLW = $clog2(MAX_MARKS + 1);
	localparam int IW  = $clog2(MAX_MARKS);
	localparam int SAVE_CNT = (SAVE_MARKS < MAX_MARKS) ? SAVE_MARKS : MAX_MARKS;

	typedef struct packed {
		logic [MLW-1:0] ml;
		logic [7:0]     pulses;
	} mark_start_t;

	function automatic mark_start_t start_mark(logic [MAX_MARKS-1:0] pat,
		logic [MLW-1:0] ml, logic [5:0] unit1);
		mark_start_t    r;
		logic           b;
		logic [MLW-1:0] idx;
		b   = 1'b0;
		idx = ml - MLW'(1);
		r.ml = '0;
		if (ml != '0) begin
			b    = pat[idx[IW-1:0]];
			r.ml = idx;
		end
		r.pulses = b ? {unit1, 2'b00} : {2'b00, unit1};
		return r;
	endfunction

	logic [5:0]  unit1;
	logic [7:0]  gap1;
	logic [9:0]  iwait1;
	logic [4:0]  cnt;
	logic [16:0] bin_mask;

	assign unit1  = (cfg.burst_unit == '0) ? 6'd1 : cfg.burst_unit;
	assign gap1   = (cfg.gap_ticks == '0) ? 8'd1 : cfg.gap_ticks;
	assign iwait1 = (cfg.interrupt_wait_ticks == '0) ? 10'd1 : cfg.interrupt_wait_ticks;
	assign cnt    = (req.bit_count > 5'(BINARY_MAX_BITS)) ? 5'(BINARY_MAX_BITS) : req.bit_count;
	assign bin_mask = (17'd1 << cnt) - 17'd1;

	always_comb begin
		tx_state_t      s;
		logic [MAX_MARKS-1:0] pat;
		logic [MLW-1:0] ml;
		logic           rej;
		logic           fin;
		logic           go;
		mark_start_t    ms;
		s   = st;
		pat = pattern;
		ml  = marks_left;
		rej = 1'b0;
		fin = 1'b0;
		go  = 1'b0;
		ms  = '0;
		if (st.phase != PH_IDLE) begin
			rej = (req.command >= CMD_TRIGGER) && (req.command <= CMD_TOGGLE);
		end else begin
			case (req.command)
				CMD_TRIGGER, CMD_TRIGGER_INT: begin
					pat = MAX_MARKS'(TRIGGER_PATTERN);
					ml  = MLW'(4);
					if (req.command == CMD_TRIGGER_INT) begin
						s.pulses_left = 8'(INTR_PULSES);
						s.half_select = 1'b0;
						s.phase       = PH_INTR;
					end else begin
						go = 1'b1;
					end
				end
				CMD_STOP: begin
					pat = MAX_MARKS'(STOP_PATTERN);
					ml  = MLW'(4);
					s.pulses_left = 8'(INTR_PULSES);
					s.half_select = 1'b0;
					s.phase       = PH_INTR;
				end
				CMD_BINARY: begin
					if (cnt != '0) begin
						pat = MAX_MARKS'(req.value & bin_mask[15:0]);
						ml  = MLW'(cnt);
						go  = 1'b1;
					end
				end
				CMD_SAVE: begin
					pat = '0;
					ml  = MLW'(SAVE_CNT);
					go  = 1'b1;
				end
				CMD_TOGGLE: begin
					s.pin_level = req.turn_on;
					s.idle_high = ~st.idle_high;
				end
				default: ;
			endcase
		end

		// advance the running sequence by one tick
		if (s.phase == PH_IDLE && !go) begin
		end else if (go || s.phase == PH_INTR || s.phase == PH_MARK) begin
			if (go) begin
				ms = start_mark(pat, ml, unit1);
				ml = ms.ml;
				s.pulses_left = ms.pulses;
				s.half_select = 1'b0;
				s.phase       = PH_MARK;
			end
			if (!s.half_select) begin
				s.pin_level   = ~s.idle_high;
				s.half_select = 1'b1;
			end else begin
				s.pin_level   = s.idle_high;
				s.half_select = 1'b0;
				if (s.pulses_left != '0)
					s.pulses_left = s.pulses_left - 8'd1;
				if (s.pulses_left == '0) begin
					s.wait_count = (s.phase == PH_INTR) ? iwait1 : 10'(gap1);
					s.phase      = PH_WAIT;
				end
			end
		end else begin
			s.pin_level = s.idle_high;
			if (s.wait_count != '0)
				s.wait_count = s.wait_count - 10'd1;
			if (s.wait_count == '0) begin
				if (ml != '0) begin
					ms = start_mark(pat, ml, unit1);
					ml = ms.ml;
					s.pulses_left = ms.pulses;
					s.half_select = 1'b0;
					s.phase       = PH_MARK;
				end else begin
					s.phase = PH_IDLE;
					fin     = 1'b1;
				end
			end
		end

		st_nxt         = s;
		pattern_nxt    = pat;
		marks_left_nxt = ml;
		res.ir_level   = s.pin_level;
		res.busy_res   = go || (s.phase != PH_IDLE) || fin;
		res.rejected   = rej;
		res.finished   = fin;
	end

endmodule

// ===== rtl/irpdt_outq.sv =====
// ----------------------------------------------------------------------------
// irpdt_outq
// Two-entry result queue between the tick logic and the result channel.
// ----------------------------------------------------------------------------
module irpdt_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  irpdt_pkg::res_t push_data,
	output logic            full,
	output logic            res_valid,
	input  logic            res_stall,
	output irpdt_pkg::res_t res
);
	import irpdt_pkg::*;

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res       = entry_q[rd_ptr_q];
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/ir_pulse_distance_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_top
// Tick-driven infrared pulse-distance transmitter.
// ----------------------------------------------------------------------------
// Each request is one carrier half tick and yields exactly one result, which
// is written into a two-entry result queue and appears on the result channel
// once it reaches the head of that queue. The sequence state updates once per
// tick, so a request is taken in every cycle while the queue is not full; the
// queue lets requests keep flowing while one result waits, and the request side
// stalls only when both entries are full. Configuration writes take effect at the
// next tick and are meant for idle periods.
module ir_pulse_distance_transmitter_top #(
	parameter int MAX_MARKS = irpdt_pkg::MAX_MARKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [irpdt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irpdt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  irpdt_pkg::req_t                   req,
	output logic                              res_valid,
	input  logic                              res_stall,
	output irpdt_pkg::res_t                   res
);
	import irpdt_pkg::*;

	localparam int MLW = $clog2(MAX_MARKS + 1);

	cfg_t                 cfg_q;
	tx_state_t            st_q;
	tx_state_t            st_nxt;
	logic [MAX_MARKS-1:0] pattern_q;
	logic [MAX_MARKS-1:0] pattern_nxt;
	logic [MLW-1:0]       marks_left_q;
	logic [MLW-1:0]       marks_left_nxt;
	res_t                 step_res;
	logic                 accept;
	logic                 q_full;

	assign req_stall = q_full;
	assign accept    = req_valid && !req_stall;

	irpdt_step #(
		.MAX_MARKS(MAX_MARKS)
	) u_step (
		.req           (req),
		.cfg           (cfg_q),
		.st            (st_q),
		.pattern       (pattern_q),
		.marks_left    (marks_left_q),
		.st_nxt        (st_nxt),
		.pattern_nxt   (pattern_nxt),
		.marks_left_nxt(marks_left_nxt),
		.res           (step_res)
	);

	irpdt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(step_res),
		.full     (q_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_unit           <= 6'd7;
			cfg_q.gap_ticks            <= 8'd22;
			cfg_q.interrupt_wait_ticks <= 10'd77;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BURST_UNIT: cfg_q.burst_unit           <= cfg_data[5:0];
				REG_GAP_TICKS:  cfg_q.gap_ticks            <= cfg_data[7:0];
				REG_INTR_WAIT:  cfg_q.interrupt_wait_ticks <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_IDLE;
			st_q.pulses_left <= '0;
			st_q.half_select <= 1'b0;
			st_q.wait_count  <= '0;
			st_q.idle_high   <= 1'b0;
			st_q.pin_level   <= 1'b0;
			pattern_q        <= '0;
			marks_left_q     <= '0;
		end else if (accept) begin
			st_q         <= st_nxt;
			pattern_q    <= pattern_nxt;
			marks_left_q <= marks_left_nxt;
		end
	end

endmodule
